>>> hw/rtl/dbbl_pkg.sv
// Shared types, codes and defaults for the decelerating blink brake light.
package dbbl_pkg;

   localparam int SAMPLES_DEFAULT     = 4;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int TIMER_BITS_DEFAULT  = 13;

   localparam int FIELD_W    = 16;
   localparam int SUM_W      = 19;
   localparam int AVG_W      = 17;
   localparam int LEVEL_W    = 4;
   localparam int COUNT_W    = 3;
   localparam int THR_W      = 16;
   localparam int INTERVAL_W = 10;
   localparam int MS_W       = 12;
   localparam int CSR_DATA_W = 16;

   localparam logic [THR_W-1:0]      LEVEL1_THR_RESET = 16'd23921;
   localparam logic [THR_W-1:0]      LEVEL2_THR_RESET = 16'd24904;
   localparam logic [THR_W-1:0]      LEVEL4_THR_RESET = 16'd25887;
   localparam logic [THR_W-1:0]      LEVEL8_THR_RESET = 16'd26870;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 10'd10;
   localparam logic [MS_W-1:0]       HOLD_RESET       = 12'd500;
   localparam logic [MS_W-1:0]       BASE_RESET       = 12'd500;
   localparam logic [MS_W-1:0]       OFF_RESET        = 12'd100;

   localparam logic [LEVEL_W-1:0] LEVEL_STEADY = 4'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1      = 4'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2      = 4'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_4      = 4'd4;
   localparam logic [LEVEL_W-1:0] LEVEL_8      = 4'd8;

   typedef struct packed {
      logic signed [FIELD_W-1:0] accel_x;
      logic signed [FIELD_W-1:0] accel_y;
      logic signed [FIELD_W-1:0] accel_z;
   } req_data_type;

   typedef struct packed {
      logic               lamp_on;
      logic [LEVEL_W-1:0] blink_level;
      logic [AVG_W-1:0]   average_magnitude;
      logic               average_ready;
   } rsp_data_type;

   typedef enum logic [2:0] {
      CSR_LEVEL1_THR,
      CSR_LEVEL2_THR,
      CSR_LEVEL4_THR,
      CSR_LEVEL8_THR,
      CSR_SAMPLE_INTERVAL,
      CSR_HOLD_AFTER_AVG,
      CSR_BLINK_BASE,
      CSR_OFF_EXTRA
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAG,
      ST_DIV,
      ST_LAMP
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SQUARE,
      PH_ROOT
   } mag_phase_type;

endpackage

>>> hw/rtl/dbbl_mag.sv
// Bit-serial sum of squares and digit-serial floor square root of one sample.
module dbbl_mag #(
   parameter int SAMPLE_BITS = dbbl_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  dbbl_pkg::req_data_type  sample,
   output logic                    done,
   output logic [SAMPLE_BITS-1:0]  root
);
   import dbbl_pkg::*;

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int CNT_W = $clog2(SAMPLE_BITS);
   localparam int REM_W = SAMPLE_BITS + 2;

   function automatic logic [SAMPLE_BITS-1:0] abs_low(input logic [FIELD_W-1:0] raw);
      logic [SAMPLE_BITS-1:0] v;
      v = raw[SAMPLE_BITS-1:0];
      return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(~v + 1'b1) : v;
   endfunction

   mag_phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             comp_ff, comp_in;
   logic [SQ_W-1:0]        mcand_ff, mcand_in;
   logic [SAMPLE_BITS-1:0] mplier_ff, mplier_in;
   logic [SAMPLE_BITS-1:0] ab_y_ff, ab_y_in;
   logic [SAMPLE_BITS-1:0] ab_z_ff, ab_z_in;
   logic [SQ_W-1:0]        acc_ff, acc_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] root_ff, root_in;
   logic                   done_ff, done_in;

   logic [SQ_W-1:0]  acc_sum;
   logic [REM_W+1:0] rem_t;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] rem_sub;
   logic             ge;
   logic             last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      comp_ff   <= comp_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      ab_y_ff   <= ab_y_in;
      ab_z_ff   <= ab_z_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
   end

   always_comb begin
      acc_sum = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
      rem_t   = {rem_ff, acc_ff[SQ_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_t >= trial;
      rem_sub = rem_t - trial;
      last    = cnt_ff == CNT_W'(SAMPLE_BITS - 1);

      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      comp_in   = comp_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      ab_y_in   = ab_y_ff;
      ab_z_in   = ab_z_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      done_in   = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               mplier_in = abs_low(sample.accel_x);
               mcand_in  = SQ_W'(abs_low(sample.accel_x));
               ab_y_in   = abs_low(sample.accel_y);
               ab_z_in   = abs_low(sample.accel_z);
               acc_in    = '0;
               cnt_in    = '0;
               comp_in   = '0;
               phase_in  = PH_SQUARE;
            end
         end
         PH_SQUARE: begin
            acc_in    = acc_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (last) begin
               cnt_in = '0;
               if (comp_ff == 2'd2) begin
                  rem_in   = '0;
                  root_in  = '0;
                  phase_in = PH_ROOT;
               end else begin
                  comp_in   = comp_ff + 1'b1;
                  mplier_in = ab_y_ff;
                  mcand_in  = SQ_W'(ab_y_ff);
                  ab_y_in   = ab_z_ff;
               end
            end
         end
         PH_ROOT: begin
            rem_in  = ge ? rem_sub[REM_W-1:0] : rem_t[REM_W-1:0];
            root_in = {root_ff[SAMPLE_BITS-2:0], ge};
            acc_in  = acc_ff << 2;
            cnt_in  = cnt_ff + 1'b1;
            if (last) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> hw/rtl/dbbl_avg.sv
// Bit-serial restoring division of the magnitude sum by the sample count.
module dbbl_avg #(
   parameter int DIVISOR = dbbl_pkg::SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [dbbl_pkg::SUM_W-1:0] dividend,
   output logic                       done,
   output logic [dbbl_pkg::SUM_W-1:0] quotient
);
   import dbbl_pkg::*;

   localparam int RW    = $clog2(DIVISOR) + 1;
   localparam int CNT_W = $clog2(SUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] dvd_ff, dvd_in;
   logic [RW-2:0]    rem_ff, rem_in;

   logic [RW-1:0] rem_t;
   logic          ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      rem_t   = {rem_ff, dvd_ff[SUM_W-1]};
      ge      = rem_t >= RW'(DIVISOR);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         rem_in = ge ? (RW-1)'(rem_t - RW'(DIVISOR)) : rem_t[RW-2:0];
         dvd_in = {dvd_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> hw/rtl/decel_blink_brake_light_core.sv
// Top level of the decelerating blink brake light: timers, averaging, levels and lamp.
// No sample due: the accepted word goes to the lamp state, which registers the result and returns to idle.
// Sample due: the word first passes through the serial magnitude unit, then the lamp state.
// A tick that also forms an average passes through the serial divide before the lamp state.
// One word is in flight at a time; the next is taken while the result waits downstream.
// Synchronous reset restores register defaults, clears timers, sum and level, lamp lit.
module decel_blink_brake_light_core #(
   parameter int SAMPLES_PER_AVERAGE = dbbl_pkg::SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS         = dbbl_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIMER_BITS          = dbbl_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dbbl_pkg::req_data_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dbbl_pkg::rsp_data_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  dbbl_pkg::csr_index_type         csr_index,
   input  logic [dbbl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dbbl_pkg::*;

   localparam int CMP_W = (TIMER_BITS > MS_W + 1 ? TIMER_BITS : MS_W + 1) + 1;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   function automatic logic [LEVEL_W-1:0] classify(
      input logic [AVG_W-1:0] a,
      input logic [THR_W-1:0] t1,
      input logic [THR_W-1:0] t2,
      input logic [THR_W-1:0] t4,
      input logic [THR_W-1:0] t8
   );
      logic [LEVEL_W-1:0] lvl;
      lvl = LEVEL_STEADY;
      if (a >= AVG_W'(t1) && a < AVG_W'(t2)) lvl = LEVEL_1;
      if (a >= AVG_W'(t2) && a < AVG_W'(t4)) lvl = LEVEL_2;
      if (a >= AVG_W'(t4) && a < AVG_W'(t8)) lvl = LEVEL_4;
      if (a >= AVG_W'(t8)) lvl = LEVEL_8;
      return lvl;
   endfunction

   logic [THR_W-1:0]      thr1_ff, thr2_ff, thr4_ff, thr8_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [MS_W-1:0]       hold_ms_ff, base_ff, off_ff;

   state_type          state_ff, state_in;
   logic [TIMER_BITS-1:0] se_ff, se_in;
   logic [TIMER_BITS-1:0] be_ff, be_in;
   logic               hold_ff, hold_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               lit_ff, lit_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic               avg_new_ff, avg_new_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   take;
   logic [TIMER_BITS-1:0]  se_tick, be_tick;
   logic [CMP_W-1:0]       wait_lim;
   logic                   mag_start, mag_done;
   logic [SAMPLE_BITS-1:0] mag_root;
   logic [SUM_W-1:0]       sum_add;
   logic [COUNT_W-1:0]     count_inc;
   logic                   avg_start, avg_done;
   logic [SUM_W-1:0]       avg_q;
   logic                   out_free;
   logic [MS_W-1:0]        on_ms;
   logic [MS_W:0]          limit;
   logic                   lit_n;
   logic [TIMER_BITS-1:0]  be_n;

   dbbl_mag #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mag (
      .clock (clock),
      .reset (reset),
      .start (mag_start),
      .sample(req_data),
      .done  (mag_done),
      .root  (mag_root)
   );

   dbbl_avg #(
      .DIVISOR(SAMPLES_PER_AVERAGE)
   ) u_avg (
      .clock   (clock),
      .reset   (reset),
      .start   (avg_start),
      .dividend(sum_add),
      .done    (avg_done),
      .quotient(avg_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr1_ff     <= LEVEL1_THR_RESET;
         thr2_ff     <= LEVEL2_THR_RESET;
         thr4_ff     <= LEVEL4_THR_RESET;
         thr8_ff     <= LEVEL8_THR_RESET;
         interval_ff <= INTERVAL_RESET;
         hold_ms_ff  <= HOLD_RESET;
         base_ff     <= BASE_RESET;
         off_ff      <= OFF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEVEL1_THR:      thr1_ff     <= csr_wdata;
            CSR_LEVEL2_THR:      thr2_ff     <= csr_wdata;
            CSR_LEVEL4_THR:      thr4_ff     <= csr_wdata;
            CSR_LEVEL8_THR:      thr8_ff     <= csr_wdata;
            CSR_SAMPLE_INTERVAL: interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_HOLD_AFTER_AVG:  hold_ms_ff  <= csr_wdata[MS_W-1:0];
            CSR_BLINK_BASE:      base_ff     <= csr_wdata[MS_W-1:0];
            CSR_OFF_EXTRA:       off_ff      <= csr_wdata[MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         se_ff        <= '0;
         be_ff        <= '0;
         hold_ff      <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         level_ff     <= LEVEL_STEADY;
         lit_ff       <= 1'b1;
         avg_ff       <= '0;
         avg_new_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         se_ff        <= se_in;
         be_ff        <= be_in;
         hold_ff      <= hold_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         level_ff     <= level_in;
         lit_ff       <= lit_in;
         avg_ff       <= avg_in;
         avg_new_ff   <= avg_new_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      accept    = req_valid && !req_stall;
      se_tick   = (se_ff == TMAX) ? se_ff : se_ff + 1'b1;
      be_tick   = (be_ff == TMAX) ? be_ff : be_ff + 1'b1;
      wait_lim  = CMP_W'(interval_ff) + (hold_ff ? CMP_W'(hold_ms_ff) : CMP_W'(0));
      take      = CMP_W'(se_tick) > wait_lim;
      mag_start = accept && take;
      sum_add   = sum_ff + SUM_W'(mag_root);
      count_inc = count_ff + 1'b1;
      avg_start = (state_ff == ST_MAG) && mag_done
                  && (count_inc >= COUNT_W'(SAMPLES_PER_AVERAGE));
      out_free  = !rsp_valid_ff || !rsp_stall;

      case (level_ff)
         LEVEL_2: on_ms = base_ff >> 1;
         LEVEL_4: on_ms = base_ff >> 2;
         LEVEL_8: on_ms = base_ff >> 3;
         default: on_ms = base_ff;
      endcase
      limit = (MS_W + 1)'(on_ms) + (lit_ff ? (MS_W + 1)'(0) : (MS_W + 1)'(off_ff));

      lit_n = lit_ff;
      be_n  = be_ff;
      if (level_ff != LEVEL_STEADY) begin
         if (CMP_W'(be_ff) > CMP_W'(limit)) begin
            if (lit_ff) begin
               lit_n = 1'b0;
            end else begin
               lit_n = 1'b1;
               be_n  = '0;
            end
         end
      end else begin
         lit_n = 1'b1;
         be_n  = '0;
      end

      state_in     = state_ff;
      se_in        = se_ff;
      be_in        = be_ff;
      hold_in      = hold_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      level_in     = level_ff;
      lit_in       = lit_ff;
      avg_in       = avg_ff;
      avg_new_in   = avg_new_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               be_in      = be_tick;
               avg_new_in = 1'b0;
               if (take) begin
                  se_in    = '0;
                  hold_in  = 1'b0;
                  state_in = ST_MAG;
               end else begin
                  se_in    = se_tick;
                  state_in = ST_LAMP;
               end
            end
         end
         ST_MAG: begin
            if (mag_done) begin
               sum_in   = sum_add;
               count_in = count_inc;
               state_in = avg_start ? ST_DIV : ST_LAMP;
            end
         end
         ST_DIV: begin
            if (avg_done) begin
               sum_in     = avg_q;
               count_in   = '0;
               hold_in    = 1'b1;
               avg_in     = avg_q[AVG_W-1:0];
               avg_new_in = 1'b1;
               level_in   = classify(avg_q[AVG_W-1:0], thr1_ff, thr2_ff, thr4_ff, thr8_ff);
               state_in   = ST_LAMP;
            end
         end
         ST_LAMP: begin
            if (out_free) begin
               lit_in                        = lit_n;
               be_in                         = be_n;
               rsp_valid_in                  = 1'b1;
               rsp_data_in.lamp_on           = lit_n;
               rsp_data_in.blink_level       = level_ff;
               rsp_data_in.average_magnitude = avg_ff;
               rsp_data_in.average_ready     = avg_new_ff;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

>>> hw/rtl/dbbl_checker.sv
// Port-level checker for the brake light core and its bind.
module dbbl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input dbbl_pkg::rsp_data_type rsp_data
);
   import dbbl_pkg::*;

   a_level_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.blink_level == LEVEL_STEADY || rsp_data.blink_level == LEVEL_1
                  || rsp_data.blink_level == LEVEL_2 || rsp_data.blink_level == LEVEL_4
                  || rsp_data.blink_level == LEVEL_8))
      else $error("blink level outside the legal set");

   a_steady_lit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.blink_level == LEVEL_STEADY) |-> rsp_data.lamp_on)
      else $error("lamp dark at steady level");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word dropped or changed");

endmodule

bind decel_blink_brake_light_core dbbl_checker u_dbbl_checker (.*);
